// ===== design/catmull_rom_to_bezier_unit_defines.svh =====
// Assertion helpers used by the curve loader.
`ifndef CATMULL_ROM_TO_BEZIER_UNIT_DEFINES_SVH
`define CATMULL_ROM_TO_BEZIER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRB_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CRB_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== design/crb_pkg.sv =====
package crb_pkg;

    // Default coordinate width, signed Q16.16.
    localparam int COORD_WIDTH_DEF = 32;

    // Tangent scale register: unsigned Q0.16.
    localparam int SCALE_WIDTH = 16;
    localparam int FRAC_BITS   = 16;
    localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = 16'd10923;

    // Point kinds within one curve.
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_CTRL1 = 2'd1;
    localparam logic [1:0] KIND_CTRL2 = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    // Control that travels with each point down the pipeline.
    typedef struct packed {
        logic [1:0] kind;
        logic       item_done;
        logic       set_done;
    } t_pt_ctrl;

endpackage

// ===== design/crb_seg_if.sv =====
interface crb_seg_if #(
    parameter int W = crb_pkg::COORD_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] start_x;
    logic signed [W-1:0] start_y;
    logic signed [W-1:0] start_z;
    logic signed [W-1:0] end_x;
    logic signed [W-1:0] end_y;
    logic signed [W-1:0] end_z;
    logic                last_segment;

    modport source (
        output valid, start_x, start_y, start_z, end_x, end_y, end_z, last_segment,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, start_z, end_x, end_y, end_z, last_segment,
        output ready
    );
endinterface

// ===== design/crb_point_if.sv =====
interface crb_point_if #(
    parameter int W = crb_pkg::COORD_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] point_x;
    logic signed [W-1:0] point_y;
    logic signed [W-1:0] point_z;
    logic [1:0]          point_kind;
    logic                item_done;
    logic                set_done;

    modport source (
        output valid, point_x, point_y, point_z, point_kind, item_done, set_done,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, point_kind, item_done, set_done,
        output ready
    );
endinterface

// ===== design/crb_curve_loader.sv =====
`include "catmull_rom_to_bezier_unit_defines.svh"

module crb_curve_loader #(
    parameter int COORD_WIDTH = crb_pkg::COORD_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    crb_seg_if.sink                         i_seg,
    input  logic                            i_down_ready,
    output logic                            o_valid,
    output logic [2:0][COORD_WIDTH-1:0]     o_base,
    output logic [2:0][COORD_WIDTH-1:0]     o_mnd,
    output logic [2:0][COORD_WIDTH-1:0]     o_sbt,
    output crb_pkg::t_pt_ctrl               o_ctrl
);

    typedef logic [2:0][COORD_WIDTH-1:0] t_vec;
    typedef struct packed {
        t_vec p0;
        t_vec p1;
        t_vec p2;
        t_vec p3;
    } t_curve;

    // Segment history.
    t_vec   r_prior_start;
    t_vec   r_prior_end;
    t_vec   r_held_start;
    t_vec   r_held_end;
    logic   r_held_valid;
    logic   r_prior_valid;

    // Job: the curve being issued and an optional final curve behind it.
    logic       r_job_valid;
    logic       r_more;
    logic       r_cur_final;
    logic [1:0] r_kind;
    t_curve     r_cur;
    t_curve     r_nxt;

    t_vec   seg_start;
    t_vec   seg_end;
    t_curve held_curve;
    t_curve final_curve;
    logic   accept;
    logic   issue;
    logic   job_end;

    assign seg_start = {i_seg.start_z, i_seg.start_y, i_seg.start_x};
    assign seg_end   = {i_seg.end_z, i_seg.end_y, i_seg.end_x};

    // The held curve borrows its neighbors only where the endpoints meet.
    always_comb begin
        held_curve.p0 = (r_prior_valid && (r_prior_end == r_held_start)) ?
                        r_prior_start : r_held_start;
        held_curve.p1 = r_held_start;
        held_curve.p2 = r_held_end;
        held_curve.p3 = (r_held_end == seg_start) ? seg_end : r_held_end;

        final_curve.p0 = (r_held_valid && (r_held_end == seg_start)) ?
                         r_held_start : seg_start;
        final_curve.p1 = seg_start;
        final_curve.p2 = seg_end;
        final_curve.p3 = seg_end;
    end

    // Handshake: a new item enters while no job is pending, or once the current job issues its last point.
    assign issue       = r_job_valid && i_down_ready;
    assign job_end     = issue && (r_kind == crb_pkg::KIND_END) && !r_more;
    assign i_seg.ready = !r_job_valid || job_end;
    assign accept      = i_seg.valid && i_seg.ready;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid  <= 1'b0;
            r_prior_valid <= 1'b0;
            r_job_valid   <= 1'b0;
            r_more        <= 1'b0;
            r_cur_final   <= 1'b0;
            r_kind        <= crb_pkg::KIND_START;
        end else if (accept) begin
            r_prior_valid <= r_held_valid && !i_seg.last_segment;
            r_held_valid  <= !i_seg.last_segment;
            r_job_valid   <= r_held_valid || i_seg.last_segment;
            r_more        <= r_held_valid && i_seg.last_segment;
            r_cur_final   <= !r_held_valid;
            r_kind        <= crb_pkg::KIND_START;
        end else if (issue) begin
            if (r_kind == crb_pkg::KIND_END) begin
                if (r_more) begin
                    r_more      <= 1'b0;
                    r_cur_final <= 1'b1;
                    r_kind      <= crb_pkg::KIND_START;
                end else begin
                    r_job_valid <= 1'b0;
                end
            end else begin
                r_kind <= r_kind + 2'd1;
            end
        end
    end

    // Segment and curve payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prior_start <= r_held_start;
            r_prior_end   <= r_held_end;
            r_held_start  <= seg_start;
            r_held_end    <= seg_end;
            r_cur         <= r_held_valid ? held_curve : final_curve;
            r_nxt         <= final_curve;
        end else if (issue && (r_kind == crb_pkg::KIND_END) && r_more) begin
            r_cur <= r_nxt;
        end
    end

    // Operands of the current point; start and end points get a zero offset.
    always_comb begin
        o_mnd = '0;
        o_sbt = '0;
        unique case (r_kind)
            crb_pkg::KIND_START: begin
                o_base = r_cur.p1;
            end
            crb_pkg::KIND_CTRL1: begin
                o_base = r_cur.p1;
                o_mnd  = r_cur.p2;
                o_sbt  = r_cur.p0;
            end
            crb_pkg::KIND_CTRL2: begin
                o_base = r_cur.p2;
                o_mnd  = r_cur.p3;
                o_sbt  = r_cur.p1;
            end
            default: begin
                o_base = r_cur.p2;
            end
        endcase
    end

    assign o_valid          = r_job_valid;
    assign o_ctrl.kind      = r_kind;
    assign o_ctrl.item_done = (r_kind == crb_pkg::KIND_END) && !r_more;
    assign o_ctrl.set_done  = (r_kind == crb_pkg::KIND_END) && r_cur_final;

    `CRB_ASSERT_NEXT(a_last_clears_history, i_clk, i_rst_n, accept && i_seg.last_segment, !r_held_valid && !r_prior_valid, "last segment left history valid")
    `CRB_ASSERT_NEXT(a_segment_held, i_clk, i_rst_n, accept && !i_seg.last_segment, r_held_valid, "accepted segment not held")
    `CRB_ASSERT_SAME(a_final_is_last, i_clk, i_rst_n, r_job_valid && r_more, !r_cur_final, "final curve issued before the held curve")

endmodule

// ===== design/crb_scale_stage.sv =====
module crb_scale_stage #(
    parameter int COORD_WIDTH = crb_pkg::COORD_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [2:0][COORD_WIDTH-1:0]         i_base,
    input  logic [2:0][COORD_WIDTH-1:0]         i_mnd,
    input  logic [2:0][COORD_WIDTH-1:0]         i_sbt,
    input  crb_pkg::t_pt_ctrl                   i_ctrl,
    input  logic [crb_pkg::SCALE_WIDTH-1:0]     i_scale,
    input  logic                                i_down_ready,
    output logic                                o_valid,
    output logic [2:0][COORD_WIDTH-1:0]         o_base,
    output logic [2:0][COORD_WIDTH:0]           o_scaled,
    output crb_pkg::t_pt_ctrl                   o_ctrl
);

    localparam int ProdWidth = COORD_WIDTH + crb_pkg::SCALE_WIDTH + 2;

    logic                             r_valid;
    logic [2:0][COORD_WIDTH-1:0]      r_base;
    logic [2:0][COORD_WIDTH:0]        r_scaled;
    crb_pkg::t_pt_ctrl                r_ctrl;
    logic [2:0][COORD_WIDTH:0]        n_scaled;
    logic                             load;

    // Per axis: difference, times the scale, floor of the Q0.16 product.
    for (genvar g = 0; g < 3; g++) begin : g_axis
        logic signed [COORD_WIDTH:0] diff;
        logic signed [ProdWidth-1:0] prod;

        assign diff = $signed({i_mnd[g][COORD_WIDTH-1], i_mnd[g]})
                    - $signed({i_sbt[g][COORD_WIDTH-1], i_sbt[g]});
        assign prod = diff * $signed({1'b0, i_scale});
        assign n_scaled[g] = prod[COORD_WIDTH+crb_pkg::FRAC_BITS:crb_pkg::FRAC_BITS];
    end

    assign o_ready = !r_valid || i_down_ready;
    assign load    = i_valid && o_ready;

    // Stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_base   <= i_base;
            r_scaled <= n_scaled;
            r_ctrl   <= i_ctrl;
        end
    end

    assign o_valid  = r_valid;
    assign o_base   = r_base;
    assign o_scaled = r_scaled;
    assign o_ctrl   = r_ctrl;

endmodule

// ===== design/crb_point_out.sv =====
module crb_point_out #(
    parameter int COORD_WIDTH = crb_pkg::COORD_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [2:0][COORD_WIDTH-1:0]     i_base,
    input  logic [2:0][COORD_WIDTH:0]       i_scaled,
    input  crb_pkg::t_pt_ctrl               i_ctrl,
    crb_point_if.source                     o_pt
);

    logic                           r_valid;
    logic [2:0][COORD_WIDTH-1:0]    r_point;
    crb_pkg::t_pt_ctrl              r_ctrl;
    logic [2:0][COORD_WIDTH-1:0]    n_point;
    logic                           load;
    logic                           subtract;

    assign subtract = (i_ctrl.kind == crb_pkg::KIND_CTRL2);

    // Per axis: add or subtract the offset, then clamp to the coordinate range.
    for (genvar g = 0; g < 3; g++) begin : g_axis
        logic signed [COORD_WIDTH+1:0] base_ext;
        logic signed [COORD_WIDTH+1:0] off_ext;
        logic signed [COORD_WIDTH+1:0] sum;
        logic                          over;

        assign base_ext = $signed({{2{i_base[g][COORD_WIDTH-1]}}, i_base[g]});
        assign off_ext  = $signed({i_scaled[g][COORD_WIDTH], i_scaled[g]});
        assign sum      = subtract ? (base_ext - off_ext) : (base_ext + off_ext);
        assign over     = (sum[COORD_WIDTH+1] != sum[COORD_WIDTH])
                       || (sum[COORD_WIDTH] != sum[COORD_WIDTH-1]);
        assign n_point[g] = !over ? sum[COORD_WIDTH-1:0] :
                            sum[COORD_WIDTH+1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}} :
                                                 {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end

    assign o_ready = !r_valid || o_pt.ready;
    assign load    = i_valid && o_ready;

    // Output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_point <= n_point;
            r_ctrl  <= i_ctrl;
        end
    end

    assign o_pt.valid      = r_valid;
    assign o_pt.point_x    = r_point[0];
    assign o_pt.point_y    = r_point[1];
    assign o_pt.point_z    = r_point[2];
    assign o_pt.point_kind = r_ctrl.kind;
    assign o_pt.item_done  = r_ctrl.item_done;
    assign o_pt.set_done   = r_ctrl.set_done;

endmodule

// ===== design/catmull_rom_to_bezier_unit.sv =====
// Turns a stream of 3D segments (signed Q16.16) into cubic Bezier curves.
// Input channel i_seg carries one segment per item with a last_segment flag;
// output channel o_pt carries one curve point per item, four per curve, in
// the order start, first control, second control, end.
// A segment's curve leaves when the next segment arrives, because the next
// start decides the second control point; a last segment flushes the held
// curve and then its own, so it yields eight points (four if nothing was held).
// i_cfg_we with i_cfg_data writes the tangent scale, unsigned Q0.16.
// The first point of an item passes the loader's curve register, the scale
// stage and the output register before it appears on o_pt. Throughput: one
// point per cycle while o_pt is ready, set by the point issuer in the loader.
// The next segment is accepted in the cycle the current job issues its last
// point, while earlier points are still in the scale and output stages.
// Synchronous reset clears the segment history and all pipeline valids and
// loads the default tangent scale. When the receiver stalls, the output
// register holds its point, and the stages behind it fill and then hold too.
module catmull_rom_to_bezier_unit #(
    parameter int COORD_WIDTH = crb_pkg::COORD_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [crb_pkg::SCALE_WIDTH-1:0] i_cfg_data,
    crb_seg_if.sink                         i_seg,
    crb_point_if.source                     o_pt
);

    logic [crb_pkg::SCALE_WIDTH-1:0] r_tangent_scale;

    logic                           ld_valid;
    logic                           sc_ready;
    logic [2:0][COORD_WIDTH-1:0]    ld_base;
    logic [2:0][COORD_WIDTH-1:0]    ld_mnd;
    logic [2:0][COORD_WIDTH-1:0]    ld_sbt;
    crb_pkg::t_pt_ctrl              ld_ctrl;

    logic                           sc_valid;
    logic                           out_ready;
    logic [2:0][COORD_WIDTH-1:0]    sc_base;
    logic [2:0][COORD_WIDTH:0]      sc_scaled;
    crb_pkg::t_pt_ctrl              sc_ctrl;

    // Tangent scale register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tangent_scale <= crb_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            r_tangent_scale <= i_cfg_data;
        end
    end

    crb_curve_loader #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_loader (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seg        (i_seg),
        .i_down_ready (sc_ready),
        .o_valid      (ld_valid),
        .o_base       (ld_base),
        .o_mnd        (ld_mnd),
        .o_sbt        (ld_sbt),
        .o_ctrl       (ld_ctrl)
    );

    crb_scale_stage #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (ld_valid),
        .o_ready      (sc_ready),
        .i_base       (ld_base),
        .i_mnd        (ld_mnd),
        .i_sbt        (ld_sbt),
        .i_ctrl       (ld_ctrl),
        .i_scale      (r_tangent_scale),
        .i_down_ready (out_ready),
        .o_valid      (sc_valid),
        .o_base       (sc_base),
        .o_scaled     (sc_scaled),
        .o_ctrl       (sc_ctrl)
    );

    crb_point_out #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (sc_valid),
        .o_ready  (out_ready),
        .i_base   (sc_base),
        .i_scaled (sc_scaled),
        .i_ctrl   (sc_ctrl),
        .o_pt     (o_pt)
    );

endmodule
